>>> rtl/btb_pkg.sv
// Shared constants for the buddy tree occupancy bitmap.
package btb_pkg;

    localparam int unsigned BIU_W  = 9;
    localparam int unsigned NODE_W = 8;

    localparam logic [BIU_W-1:0] BIU_RESET = 9'd256;

    localparam logic [2:0]  BYTE_MASK = 3'h7;
    localparam int unsigned BYTE_LAST = 7;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CHECK = 2'd2;

endpackage

>>> rtl/btb_limits.sv
// Effective node count and byte-rounded index limit from the bits-in-use setting.
module btb_limits #(
    parameter int unsigned MAX_NODES = 256,
    parameter int unsigned IW        = 9
) (
    input  logic [btb_pkg::BIU_W-1:0] bits_in_use,
    output logic [IW-1:0]             eff_bits,
    output logic [IW-1:0]             index_limit
);
    import btb_pkg::*;

    logic [IW-1:0] biu_ext;
    logic [IW-1:0] max_ext;
    logic [IW-1:0] rounded;

    assign biu_ext  = IW'(bits_in_use);
    assign max_ext  = IW'(MAX_NODES);
    assign eff_bits = (biu_ext > max_ext) ? max_ext : biu_ext;
    assign rounded  = (eff_bits + IW'(BYTE_LAST)) & ~IW'(BYTE_MASK);
    assign index_limit = (rounded > max_ext) ? max_ext : rounded;

endmodule

>>> rtl/buddy_tree_bitmap_core.sv
// Top level of the buddy tree occupancy bitmap: sequencer, bit store and result register.
//
// Input channel (in_valid / in_stall) carries one request: req_type, node_index, bit_value.
// Output channel (out_valid / out_stall) returns one result per request: answer_bit and
// range_error. cfg_we / cfg_data write bits_in_use (reset 256); the user must write it
// only while the block is idle, as the block itself does not enforce it. The bits live
// in a memory of MAX_NODES/8 eight-bit words with one read and one write port and
// registered read data; a single sequencer walks every request through it. Read: the
// request passes S_FETCH, S_BIT and S_DONE to the result register. Write: the same
// path, as a read-modify-write in S_BIT. Unknown type and rejected indexes go straight
// to S_DONE. Subtree check: S_LEVEL, then S_SCAN and S_TEST for each tree level, with
// S_TEST once per memory word scanned; the word scan takes most of the time.
// One request is in work at a time; in_stall is high from accept until the result is
// loaded into the output register, which may still wait on out_stall meanwhile.
// A result held by out_stall blocks completion of the next request only.
// After reset a clearing pass writes every word to free, with in_stall high;
// configuration writes are taken as ever.
// MAX_NODES must be a multiple of 8.
module buddy_tree_bitmap_core #(
    parameter int unsigned MAX_NODES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  req_type,
    input  logic [btb_pkg::NODE_W-1:0]  node_index,
    input  logic                        bit_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        answer_bit,
    output logic                        range_error,
    input  logic                        cfg_we,
    input  logic [btb_pkg::BIU_W-1:0]   cfg_data
);
    import btb_pkg::*;

    localparam int unsigned CW    = $clog2(MAX_NODES) + 1;
    localparam int unsigned IW    = (CW > 9) ? CW : 9;
    localparam int unsigned WORDS = MAX_NODES / 8;
    localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned WW    = IW - 3;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_FETCH = 8'b0000_0100,
        S_BIT   = 8'b0000_1000,
        S_LEVEL = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_TEST  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [BIU_W-1:0] biu_reg;
    logic [AW-1:0]    clr_ptr_reg, clr_ptr_next;
    logic [1:0]       req_reg, req_next;
    logic             bitv_reg, bitv_next;
    logic [2:0]       bsel_reg, bsel_next;
    logic [IW-1:0]    child_reg, child_next;
    logic [IW-1:0]    width_reg, width_next;
    logic [WW-1:0]    wp_reg, wp_next;
    logic [WW-1:0]    wend_reg, wend_next;
    logic [7:0]       mask_reg, mask_next;
    logic             ans_reg, ans_next;
    logic             err_reg, err_next;
    logic             out_valid_reg, out_valid_next;
    logic             answer_reg, answer_next;
    logic             range_error_reg, range_error_next;

    logic [IW-1:0]    eff_bits;
    logic [IW-1:0]    index_limit;
    logic [IW-1:0]    node_ext;
    logic [WW-1:0]    wp_inc;
    logic [7:0]       wr_word;
    logic [7:0]       small_mask;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [7:0]       rdata_reg;
    logic [7:0]       mem [0:WORDS-1];

    btb_limits #(
        .MAX_NODES (MAX_NODES),
        .IW        (IW)
    ) u_limits (
        .bits_in_use (biu_reg),
        .eff_bits    (eff_bits),
        .index_limit (index_limit)
    );

    assign node_ext   = IW'(node_index);
    assign wp_inc     = WW'(wp_reg + WW'(1));
    assign small_mask = width_reg[2] ? 8'h0F : 8'h03;

    always_comb
    begin
        wr_word = rdata_reg;
        wr_word[bsel_reg] = bitv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_ptr_next     = clr_ptr_reg;
        req_next         = req_reg;
        bitv_next        = bitv_reg;
        bsel_next        = bsel_reg;
        child_next       = child_reg;
        width_next       = width_reg;
        wp_next          = wp_reg;
        wend_next        = wend_reg;
        mask_next        = mask_reg;
        ans_next         = ans_reg;
        err_next         = err_reg;
        answer_next      = answer_reg;
        range_error_next = range_error_reg;
        out_valid_next   = out_valid_reg && out_stall;
        mem_we           = 1'b0;
        mem_waddr        = wp_reg[AW-1:0];
        mem_wdata        = wr_word;
        mem_raddr        = wp_reg[AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_ptr_reg;
                mem_wdata    = 8'h00;
                clr_ptr_next = AW'(clr_ptr_reg + AW'(1));
                if (clr_ptr_reg == AW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = req_type;
                    bitv_next = bit_value;
                    bsel_next = node_index[2:0];
                    ans_next  = 1'b0;
                    err_next  = 1'b0;
                    case (req_type)
                        REQ_WRITE, REQ_READ:
                        begin
                            if (node_ext < index_limit)
                            begin
                                wp_next    = WW'(node_ext >> 3);
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                        end
                        REQ_CHECK:
                        begin
                            if (node_index == '0)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                child_next = IW'(node_ext << 1);
                                width_next = IW'(2);
                                state_next = S_LEVEL;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = S_BIT;
            end
            S_BIT:
            begin
                if (req_reg == REQ_READ)
                begin
                    ans_next = rdata_reg[bsel_reg];
                end
                else
                begin
                    mem_we = 1'b1;
                end
                state_next = S_DONE;
            end
            S_LEVEL:
            begin
                if (child_reg >= eff_bits)
                begin
                    ans_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    wp_next   = WW'(child_reg >> 3);
                    wend_next = WW'((child_reg + width_reg - IW'(1)) >> 3);
                    if (width_reg[IW-1:3] != '0)
                    begin
                        mask_next = 8'hFF;
                    end
                    else
                    begin
                        mask_next = 8'(small_mask << child_reg[2:0]);
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ({wp_reg, 3'b000} >= index_limit)
                begin
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if ((rdata_reg & mask_reg) != 8'h00)
                begin
                    state_next = S_DONE;
                end
                else if (wp_reg == wend_reg)
                begin
                    child_next = IW'(child_reg << 1);
                    width_next = IW'(width_reg << 1);
                    state_next = S_LEVEL;
                end
                else
                begin
                    wp_next   = wp_inc;
                    mask_next = 8'hFF;
                    mem_raddr = wp_inc[AW-1:0];
                    if ({wp_inc, 3'b000} < index_limit)
                    begin
                        state_next = S_TEST;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    answer_next      = ans_reg;
                    range_error_next = err_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_ptr_reg   <= '0;
            out_valid_reg <= 1'b0;
            biu_reg       <= BIU_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                biu_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        bitv_reg        <= bitv_next;
        bsel_reg        <= bsel_next;
        child_reg       <= child_next;
        width_reg       <= width_next;
        wp_reg          <= wp_next;
        wend_reg        <= wend_next;
        mask_reg        <= mask_next;
        ans_reg         <= ans_next;
        err_reg         <= err_next;
        answer_reg      <= answer_next;
        range_error_reg <= range_error_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign answer_bit  = answer_reg;
    assign range_error = range_error_reg;

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted but block not busy next cycle");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !mem_we)
        else $error("store written outside a request or clear pass");

    a_no_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !out_valid)
        else $error("result presented during clear pass");

    a_answer_excl_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(answer_bit && range_error))
        else $error("answer and range error both set");

endmodule
